// File: src/lmps_pkg.sv
// ----------------------------------------------------------------------------
// lmps_pkg
// Shared types and codes for the LED matrix PWM scanner.
// ----------------------------------------------------------------------------
package lmps_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_CLEAR = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    localparam logic KIND_DRIVE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    localparam logic [7:0] PERIOD_RESET = 8'd10;

    typedef struct packed {
        logic       wr;
        logic       clr;
        logic [2:0] row;
        logic [2:0] col;
        logic [7:0] data;
    } store_cmd_t;

endpackage

// File: src/lmps_store.sv
// ----------------------------------------------------------------------------
// lmps_store
// Pixel memory: one word per column, one byte lane per row. Per-word valid
// bits give the cleared state; a write to a cleared word zero-fills it.
// ----------------------------------------------------------------------------
module lmps_store
    import lmps_pkg::*;
#(
    parameter int ROWS = 7,
    parameter int COLS = 5
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  store_cmd_t          cmd,
    input  logic                rd_en,
    input  logic [2:0]          rd_col,
    output logic [ROWS*8-1:0]   rd_word
);

    localparam int         AW     = (COLS > 1) ? $clog2(COLS) : 1;
    localparam logic [3:0] ROWS_L = 4'(ROWS);
    localparam logic [3:0] COLS_L = 4'(COLS);

    logic [ROWS*8-1:0] mem [COLS];
    logic [COLS-1:0]   valid_reg, valid_next;
    logic [ROWS*8-1:0] rd_word_reg;
    logic              rd_valid_reg;

    logic              wr_fire;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic [ROWS-1:0]   lane_en;
    logic [ROWS*8-1:0] lane_data;

    assign wr_fire = cmd.wr && ({1'b0, cmd.row} < ROWS_L) && ({1'b0, cmd.col} < COLS_L);
    assign wr_addr = wr_fire ? cmd.col[AW-1:0] : '0;
    assign rd_addr = ({1'b0, rd_col} < COLS_L) ? rd_col[AW-1:0] : '0;

    always_comb begin
        for (int i = 0; i < ROWS; i++) begin
            lane_en[i]          = (cmd.row == 3'(i)) || !valid_reg[wr_addr];
            lane_data[i*8 +: 8] = (cmd.row == 3'(i)) ? cmd.data : 8'd0;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (cmd.clr) begin
            valid_next = '0;
        end else if (wr_fire) begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_fire) begin
            for (int i = 0; i < ROWS; i++) begin
                if (lane_en[i]) begin
                    mem[wr_addr][i*8 +: 8] <= lane_data[i*8 +: 8];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_word_reg  <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_word = rd_valid_reg ? rd_word_reg : '0;

endmodule

// File: src/led_matrix_pwm_scanner.sv
// ----------------------------------------------------------------------------
// led_matrix_pwm_scanner
// Column-scanned PWM driver for a small LED matrix with pixel write/read.
// ----------------------------------------------------------------------------
// A tick or read result passes the memory read register, then the output register.
// Throughput: one request per cycle while m_tready is high; with the result
// stalled the read stage holds one more request, then s_tready drops.
// Writes and clears complete in the cycle they are taken and give no result.
// Reset: column and PWM counters cleared, period set to 10, all pixel words
// marked cleared at once (no sweep needed).
module led_matrix_pwm_scanner
    import lmps_pkg::*;
#(
    parameter int ROWS = 7,
    parameter int COLS = 5
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // pixel_row[2:0], pixel_col[5:3], intensity[13:6]
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // row_mask[7:0], column_index[10:8], pixel_value[18:11]
    output logic        m_tuser,   // kind[0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    localparam logic [3:0] ROWS_L   = 4'(ROWS);
    localparam logic [3:0] COLS_L   = 4'(COLS);
    localparam logic [2:0] COL_LAST = 3'(COLS - 1);

    op_t               op;
    logic [2:0]        pixel_row;
    logic [2:0]        pixel_col;
    logic [7:0]        intensity;
    logic              accept;
    logic              in_range;
    logic              s1_adv;
    store_cmd_t        cmd;
    logic              rd_en;
    logic [2:0]        rd_col;
    logic [ROWS*8-1:0] rd_word;

    logic [7:0] period_reg;
    logic [2:0] scan_col_reg, scan_col_next;
    logic [7:0] pwm_reg, pwm_next;
    logic [8:0] pwm_inc;

    logic       s1_valid_reg, s1_valid_next;
    logic       s1_kind_reg;
    logic [2:0] s1_row_reg;
    logic [2:0] s1_col_reg;
    logic [7:0] s1_pwm_reg;
    logic       s1_range_reg;

    logic [7:0] pattern;
    logic [7:0] read_value;

    logic        m_valid_reg, m_valid_next;
    logic [23:0] m_data_reg;
    logic        m_user_reg;

    assign op        = op_t'(s_tuser);
    assign pixel_row = s_tdata[2:0];
    assign pixel_col = s_tdata[5:3];
    assign intensity = s_tdata[13:6];

    assign s1_adv   = !m_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || s1_adv;
    assign accept   = s_tvalid && s_tready;
    assign in_range = ({1'b0, pixel_row} < ROWS_L) && ({1'b0, pixel_col} < COLS_L);

    assign cfg_ready = 1'b1;

    always_comb begin
        cmd.wr   = accept && (op == OP_WRITE);
        cmd.clr  = accept && (op == OP_CLEAR);
        cmd.row  = pixel_row;
        cmd.col  = pixel_col;
        cmd.data = intensity;
        rd_en    = accept && ((op == OP_TICK) || (op == OP_READ));
        rd_col   = (op == OP_TICK) ? (COL_LAST - scan_col_reg) : pixel_col;
    end

    lmps_store #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .rd_en   (rd_en),
        .rd_col  (rd_col),
        .rd_word (rd_word)
    );

    // scan and PWM counters
    assign pwm_inc = {1'b0, pwm_reg} + 9'd1;

    always_comb begin
        scan_col_next = scan_col_reg;
        pwm_next      = pwm_reg;
        if (accept && (op == OP_TICK)) begin
            scan_col_next = (scan_col_reg == COL_LAST) ? 3'd0 : scan_col_reg + 3'd1;
            pwm_next      = (pwm_inc >= {1'b0, period_reg}) ? 8'd0 : pwm_inc[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg   <= PERIOD_RESET;
            scan_col_reg <= '0;
            pwm_reg      <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                period_reg <= cfg_data;
            end
            scan_col_reg <= scan_col_next;
            pwm_reg      <= pwm_next;
        end
    end

    // stage 1: memory read in flight
    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = rd_en;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_kind_reg  <= (op == OP_READ) ? KIND_READ : KIND_DRIVE;
            s1_row_reg   <= pixel_row;
            s1_col_reg   <= scan_col_reg;
            s1_pwm_reg   <= pwm_reg;
            s1_range_reg <= in_range;
        end
    end

    // stage 2: compare and pack
    always_comb begin
        pattern    = '0;
        read_value = '0;
        for (int r = 0; r < ROWS; r++) begin
            if (rd_word[r*8 +: 8] > s1_pwm_reg) begin
                pattern[ROWS-1-r] = 1'b1;
            end
            if (s1_range_reg && (s1_row_reg == 3'(r))) begin
                read_value = rd_word[r*8 +: 8];
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s1_adv) begin
            m_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv && s1_valid_reg) begin
            m_user_reg <= s1_kind_reg;
            if (s1_kind_reg == KIND_READ) begin
                m_data_reg <= {5'd0, read_value, 3'd0, 8'd0};
            end else begin
                m_data_reg <= {5'd0, 8'd0, s1_col_reg, pattern};
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// File: src/lmps_checker.sv
// ----------------------------------------------------------------------------
// lmps_checker
// Port-level checks for the LED matrix PWM scanner, bound to the top level.
// ----------------------------------------------------------------------------
module lmps_checker
    import lmps_pkg::*;
#(
    parameter int ROWS = 7,
    parameter int COLS = 5
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser,
    input logic        cfg_ready
);

    localparam logic [2:0] COL_LAST = 3'(COLS - 1);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result dropped or changed while stalled");

    a_read_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_READ) |-> m_tdata[10:0] == 11'd0)
        else $error("read result carries drive fields");

    a_drive_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_DRIVE) |->
            (m_tdata[18:11] == 8'd0) && (m_tdata[10:8] <= COL_LAST)
            && ((m_tdata[7:0] >> ROWS) == 8'd0))
        else $error("drive result out of range");

    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("config channel not ready");

endmodule

bind led_matrix_pwm_scanner lmps_checker #(
    .ROWS (ROWS),
    .COLS (COLS)
) u_lmps_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_ready (cfg_ready)
);

// File: dv/led_matrix_pwm_scanner_test.sv
// ----------------------------------------------------------------------------
// led_matrix_pwm_scanner_test
// Self-checking bench for the LED matrix PWM scanner. A short directed table
// covers reset state, range edges, mirrored column scan and clear; then
// random requests run under several PWM periods (zero, one, max, lowered
// below the running count) while both stream sides idle at random in some phases. A local
// pixel store and scan/PWM counters predict every column drive and pixel read.
// ----------------------------------------------------------------------------
module led_matrix_pwm_scanner_test;
    import lmps_pkg::*;

    localparam int ROWS = 7;
    localparam int COLS = 5;
    localparam int N_DIRECTED = 24;
    localparam int N_PHASES = 6;
    localparam int ITEMS_PER_PHASE = 113;
    localparam int DRAIN_CYCLES = 6;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic       kind;
        logic [7:0] pattern;
        logic [2:0] column;
        logic [7:0] level;
    } scan_result_t;

    typedef struct packed {
        op_t          op;
        logic [2:0]   row;
        logic [2:0]   col;
        logic [7:0]   inten;
        logic         typed;
        scan_result_t want;
    } stim_row_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [1:0]  s_tuser = OP_TICK;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = '0;

    // typed expectation travels with the request it belongs to
    logic         req_typed = 1'b0;
    scan_result_t req_want = '0;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int error_count = 0;
    int cycle_count = 0;

    logic [7:0]   pixel_mirror [ROWS*COLS];
    logic [2:0]   scan_col;
    logic [7:0]   pwm_cnt;
    logic [7:0]   pwm_period;
    scan_result_t pending_results [$];

    stim_row_t directed_rows [N_DIRECTED];

    led_matrix_pwm_scanner #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // pixel_row[2:0], pixel_col[5:3], intensity[13:6]
        .s_tuser  (s_tuser),   // op[1:0]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // row_mask[7:0], column_index[10:8], pixel_value[18:11]
        .m_tuser  (m_tuser),   // kind[0]
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch @%0d: %s", cycle_count, msg);
        error_count++;
    endtask

    task automatic compare_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    function automatic bit predict_scan(input op_t op, input logic [2:0] row,
                                        input logic [2:0] col, input logic [7:0] inten,
                                        output scan_result_t res);
        bit          in_range;
        int          src;
        int          nxt;
        logic [7:0]  pattern;
        in_range = (row < ROWS) && (col < COLS);
        res = '0;
        case (op)
            OP_TICK: begin
                src = COLS - 1 - int'(scan_col);
                pattern = '0;
                for (int r = 0; r < ROWS; r++)
                    if (pixel_mirror[r*COLS + src] > pwm_cnt)
                        pattern[ROWS-1-r] = 1'b1;
                res.kind = KIND_DRIVE;
                res.pattern = pattern;
                res.column = scan_col;
                scan_col = 3'((int'(scan_col) + 1) % COLS);
                nxt = int'(pwm_cnt) + 1;
                if (nxt >= int'(pwm_period))
                    nxt = 0;
                pwm_cnt = nxt[7:0];
                return 1'b1;
            end
            OP_WRITE: begin
                if (in_range)
                    pixel_mirror[int'(row)*COLS + int'(col)] = inten;
                return 1'b0;
            end
            OP_CLEAR: begin
                foreach (pixel_mirror[i])
                    pixel_mirror[i] = '0;
                return 1'b0;
            end
            default: begin
                res.kind = KIND_READ;
                res.level = in_range ? pixel_mirror[int'(row)*COLS + int'(col)] : 8'd0;
                return 1'b1;
            end
        endcase
    endfunction

    // bus observer: requests feed the predictor, results are checked in order
    always @(posedge aclk) begin
        scan_result_t res;
        scan_result_t want;
        if (!aresetn) begin
            foreach (pixel_mirror[i])
                pixel_mirror[i] = '0;
            scan_col = '0;
            pwm_cnt = '0;
            pwm_period = PERIOD_RESET;
        end else begin
            if (cfg_valid && cfg_ready)
                pwm_period = cfg_data;
            if (s_tvalid && s_tready) begin
                if (predict_scan(op_t'(s_tuser), s_tdata[2:0], s_tdata[5:3],
                                 s_tdata[13:6], res))
                    pending_results.push_back(req_typed ? req_want : res);
            end
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    want = pending_results.pop_front();
                    compare_field("kind", m_tuser, want.kind);
                    compare_field("row_mask", m_tdata[7:0], want.pattern);
                    compare_field("column_index", m_tdata[10:8], want.column);
                    compare_field("pixel_value", m_tdata[18:11], want.level);
                end
            end
        end
    end

    task automatic send_request(input op_t op, input logic [2:0] row, input logic [2:0] col,
                                input logic [7:0] inten, input logic typed,
                                input scan_result_t want);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {2'b00, inten, col, row};
        req_typed <= typed;
        req_want <= want;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_period(input logic [7:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random();
        op_t        op;
        logic [2:0] row;
        logic [2:0] col;
        logic [7:0] inten;
        int         pick;
        pick = $urandom_range(99);
        if (pick < 42)
            op = OP_TICK;
        else if (pick < 72)
            op = OP_WRITE;
        else if (pick < 98)
            op = OP_READ;
        else
            op = OP_CLEAR;
        row = ($urandom_range(7) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(ROWS-1));
        col = ($urandom_range(7) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(COLS-1));
        inten = $urandom_range(1) ? 8'($urandom_range(255)) : 8'($urandom_range(15));
        send_request(op, row, col, inten, 1'b0, '0);
    endtask

    initial begin
        logic [7:0] periods [N_PHASES];

        directed_rows = '{
            '{OP_TICK,  3'd0, 3'd0, 8'd0,   1'b1, '{KIND_DRIVE, 8'h00, 3'd0, 8'd0}},
            '{OP_READ,  3'd0, 3'd0, 8'd0,   1'b1, '{KIND_READ,  8'h00, 3'd0, 8'd0}},
            '{OP_WRITE, 3'd0, 3'd4, 8'd255, 1'b0, '0},
            '{OP_WRITE, 3'd6, 3'd4, 8'd1,   1'b0, '0},
            '{OP_WRITE, 3'd0, 3'd0, 8'd128, 1'b0, '0},
            '{OP_WRITE, 3'd7, 3'd0, 8'd77,  1'b0, '0},
            '{OP_WRITE, 3'd0, 3'd5, 8'd99,  1'b0, '0},
            '{OP_WRITE, 3'd7, 3'd7, 8'd200, 1'b0, '0},
            '{OP_READ,  3'd0, 3'd4, 8'd0,   1'b1, '{KIND_READ,  8'h00, 3'd0, 8'd255}},
            '{OP_READ,  3'd6, 3'd4, 8'd0,   1'b1, '{KIND_READ,  8'h00, 3'd0, 8'd1}},
            '{OP_READ,  3'd7, 3'd0, 8'd0,   1'b1, '{KIND_READ,  8'h00, 3'd0, 8'd0}},
            '{OP_READ,  3'd0, 3'd5, 8'd0,   1'b1, '{KIND_READ,  8'h00, 3'd0, 8'd0}},
            '{OP_READ,  3'd7, 3'd7, 8'd255, 1'b1, '{KIND_READ,  8'h00, 3'd0, 8'd0}},
            '{OP_TICK,  3'd7, 3'd7, 8'd255, 1'b0, '0},
            '{OP_TICK,  3'd0, 3'd0, 8'd0,   1'b0, '0},
            '{OP_TICK,  3'd0, 3'd0, 8'd0,   1'b0, '0},
            '{OP_TICK,  3'd0, 3'd0, 8'd0,   1'b0, '0},
            '{OP_TICK,  3'd0, 3'd0, 8'd0,   1'b0, '0},
            '{OP_WRITE, 3'd3, 3'd2, 8'd170, 1'b0, '0},
            '{OP_READ,  3'd3, 3'd2, 8'd0,   1'b1, '{KIND_READ,  8'h00, 3'd0, 8'd170}},
            '{OP_READ,  3'd0, 3'd0, 8'd0,   1'b1, '{KIND_READ,  8'h00, 3'd0, 8'd128}},
            '{OP_CLEAR, 3'd0, 3'd0, 8'd0,   1'b0, '0},
            '{OP_READ,  3'd0, 3'd4, 8'd0,   1'b1, '{KIND_READ,  8'h00, 3'd0, 8'd0}},
            '{OP_TICK,  3'd0, 3'd0, 8'd0,   1'b0, '0}
        };
        // max period lets the count climb, then 3 drops below it
        periods = '{8'd255, 8'd3, 8'd0, 8'd1, 8'($urandom_range(2, 12)),
                    8'($urandom_range(1, 255))};

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_pct = 21;
        rx_idle_pct = 75;
        for (int i = 0; i < N_DIRECTED; i++)
            send_request(directed_rows[i].op, directed_rows[i].row, directed_rows[i].col,
                         directed_rows[i].inten, directed_rows[i].typed,
                         directed_rows[i].want);

        for (int p = 0; p < N_PHASES; p++) begin
            case (p / 2)
                0: begin
                    tx_idle_pct = 21;
                    rx_idle_pct = 75;
                end
                1: begin
                    tx_idle_pct = 75;
                    rx_idle_pct = 21;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            write_period(periods[p]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(63) == 0)
                    wait_drained();
                send_random();
            end
        end

        wait_drained();
        if (pending_results.size() != 0)
            report_mismatch("expected results left over");
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
